### hdl/pm0_pkg.sv
// Package: default sizes, opcodes, function codes and fault codes of the PM/0 execute unit.
`default_nettype none
package pm0_pkg;

  localparam int STACK_DEPTH_DEF = 2048;
  localparam int CODE_DEPTH_DEF  = 512;
  localparam int MAX_LEVELS_DEF  = 3;

  localparam int DATA_W  = 32;
  localparam int FAULT_W = 3;

  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_SIO = 4'd9;

  localparam logic signed [31:0] OPR_RET = 32'sd0;
  localparam logic signed [31:0] OPR_NEG = 32'sd1;
  localparam logic signed [31:0] OPR_ADD = 32'sd2;
  localparam logic signed [31:0] OPR_SUB = 32'sd3;
  localparam logic signed [31:0] OPR_MUL = 32'sd4;
  localparam logic signed [31:0] OPR_DIV = 32'sd5;
  localparam logic signed [31:0] OPR_ODD = 32'sd6;
  localparam logic signed [31:0] OPR_MOD = 32'sd7;
  localparam logic signed [31:0] OPR_EQL = 32'sd8;
  localparam logic signed [31:0] OPR_NEQ = 32'sd9;
  localparam logic signed [31:0] OPR_LSS = 32'sd10;
  localparam logic signed [31:0] OPR_LEQ = 32'sd11;
  localparam logic signed [31:0] OPR_GTR = 32'sd12;
  localparam logic signed [31:0] OPR_GEQ = 32'sd13;

  localparam logic signed [31:0] SIO_PRINT = 32'sd1;
  localparam logic signed [31:0] SIO_READ  = 32'sd2;
  localparam logic signed [31:0] SIO_HALT  = 32'sd3;

  localparam logic [FAULT_W-1:0] FLT_NONE  = 3'd0;
  localparam logic [FAULT_W-1:0] FLT_OPC   = 3'd1;
  localparam logic [FAULT_W-1:0] FLT_FUNC  = 3'd2;
  localparam logic [FAULT_W-1:0] FLT_DIV0  = 3'd3;
  localparam logic [FAULT_W-1:0] FLT_RANGE = 3'd4;

endpackage
`default_nettype wire

### hdl/pm0_if.sv
// Interfaces: instruction channel and result channel of the PM/0 execute unit.
`default_nettype none
interface pm0_in_if import pm0_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [3:0]               opcode;
  logic [1:0]               level;
  logic signed [DATA_W-1:0] operand;
  logic signed [DATA_W-1:0] read_value;
  modport source (output valid, opcode, level, operand, read_value, input ready);
  modport sink   (input valid, opcode, level, operand, read_value, output ready);
endinterface

interface pm0_out_if import pm0_pkg::*; #(
  parameter int CW = 9,
  parameter int SW = 11
) ();
  logic                     valid;
  logic                     ready;
  logic [CW-1:0]            next_pc;
  logic [SW-1:0]            base_ptr;
  logic [SW-1:0]            stack_ptr;
  logic                     print_valid;
  logic signed [DATA_W-1:0] print_value;
  logic                     halted;
  logic [FAULT_W-1:0]       fault;
  modport source (output valid, next_pc, base_ptr, stack_ptr, print_valid, print_value,
                  halted, fault, input ready);
  modport sink   (input valid, next_pc, base_ptr, stack_ptr, print_valid, print_value,
                  halted, fault, output ready);
endinterface
`default_nettype wire

### hdl/pm0_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pm0_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/pl0_stack_machine_execute.sv
// PM/0 stack-machine execute unit: one instruction per item against a RAM data stack.
// Steps: accept, walk the static links (S_WALK and S_WALKW per link), plan the checks and reads,
// read the stack words, execute, run the bit-serial divider for DIV and MOD, write the planned
// words and commit the result. One item is in flight; the next is taken the cycle after the
// result is registered, and a stalled result holds the unit.
// After reset a clearing pass zeroes every stack word, one per cycle.
`default_nettype none
module pl0_stack_machine_execute import pm0_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int CODE_DEPTH  = CODE_DEPTH_DEF,
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  pm0_in_if.sink     in_i,
  pm0_out_if.source  out_o
);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(CODE_DEPTH);
  localparam int XW = 34;

  typedef logic signed [XW-1:0] xaddr_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_WALKW, S_PLAN, S_RDA, S_RDB, S_EXEC, S_DIV, S_WR, S_FIN
  } state_e;

  function automatic logic s_ok(input xaddr_t a);
    return (a >= 0) && (a < XW'(STACK_DEPTH));
  endfunction

  function automatic logic c_ok(input xaddr_t a);
    return (a >= 0) && (a < XW'(CODE_DEPTH));
  endfunction

  function automatic xaddr_t sx(input logic [DATA_W-1:0] v);
    return xaddr_t'($signed(v));
  endfunction

  state_e state_q;
  logic [SW-1:0] clr_q;
  logic [CW-1:0] pc_q;
  logic [SW-1:0] bp_q, sp_q;

  logic [3:0]              op_q;
  logic signed [DATA_W-1:0] m_q, rv_q, b_q, x_q, y_q;
  logic [1:0]              walk_q;
  logic [1:0]              nrd_q;
  logic [SW-1:0]           rd1_q, a_q;

  logic [FAULT_W-1:0] flt_q;
  logic [CW-1:0]      np_q;
  logic [SW-1:0]      nb_q, ns_q;
  logic [2:0]         nw_q;
  logic [1:0]         wcnt_q;
  logic [SW-1:0]      wa_q;
  logic [DATA_W-1:0]  wv_q;
  logic               pvld_q, halt_q, cal_q;

  logic [DATA_W-1:0] dvd_q, dvs_q;
  logic [DATA_W:0]   rem_q;
  logic [5:0]        dcnt_q;
  logic              qneg_q, rneg_q, ismod_q;

  logic              out_valid_q;
  logic [CW-1:0]     o_pc_q;
  logic [SW-1:0]     o_bp_q, o_sp_q;
  logic              o_pv_q, o_halt_q;
  logic [DATA_W-1:0] o_pval_q;
  logic [FAULT_W-1:0] o_flt_q;

  logic              mem_we;
  logic [SW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  pm0_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Common views of the registers in wide signed form.
  xaddr_t sp_x, bp_x, b_x, m_x, a_x;
  logic [CW-1:0] pc1;
  always_comb begin
    sp_x = xaddr_t'({1'b0, sp_q});
    bp_x = xaddr_t'({1'b0, bp_q});
    b_x  = sx(b_q);
    m_x  = sx(m_q);
    a_x  = b_x + m_x;
    pc1  = (XW'(pc_q) + 1 >= XW'(CODE_DEPTH)) ? '0 : CW'(pc_q + 1'b1);
  end

  // Range checks and read addresses, once the static-link walk is done.
  logic [FAULT_W-1:0] pl_flt;
  logic [1:0]         pl_nrd;
  xaddr_t             pl_rd0, pl_rd1;
  always_comb begin
    pl_flt = FLT_NONE;
    pl_nrd = 2'd0;
    pl_rd0 = sp_x;
    pl_rd1 = sp_x;
    case (op_q)
      OP_LIT: if (!s_ok(sp_x + 1)) pl_flt = FLT_RANGE;
      OP_OPR: begin
        if (m_q == OPR_RET) begin
          if (!s_ok(bp_x - 1) || !s_ok(bp_x + 3)) pl_flt = FLT_RANGE;
          pl_rd0 = bp_x + 2;
          pl_rd1 = bp_x + 3;
          pl_nrd = 2'd2;
        end else if (m_q == OPR_NEG || m_q == OPR_ODD) begin
          if (!s_ok(sp_x)) pl_flt = FLT_RANGE;
          pl_nrd = 2'd1;
        end else if (m_q >= OPR_ADD && m_q <= OPR_GEQ) begin
          if (!s_ok(sp_x - 1) || !s_ok(sp_x)) pl_flt = FLT_RANGE;
          pl_rd0 = sp_x - 1;
          pl_nrd = 2'd2;
        end else begin
          pl_flt = FLT_FUNC;
        end
      end
      OP_LOD: begin
        if (!s_ok(a_x) || !s_ok(sp_x + 1)) pl_flt = FLT_RANGE;
        pl_rd0 = a_x;
        pl_nrd = 2'd1;
      end
      OP_STO: begin
        if (!s_ok(a_x) || !s_ok(sp_x) || !s_ok(sp_x - 1)) pl_flt = FLT_RANGE;
        pl_nrd = 2'd1;
      end
      OP_CAL: if (!s_ok(sp_x + 1) || !s_ok(sp_x + 4) || !c_ok(m_x)) pl_flt = FLT_RANGE;
      OP_INC: if (!s_ok(sp_x + m_x)) pl_flt = FLT_RANGE;
      OP_JMP: if (!c_ok(m_x)) pl_flt = FLT_RANGE;
      OP_JPC: begin
        if (!s_ok(sp_x) || !s_ok(sp_x - 1)) pl_flt = FLT_RANGE;
        pl_nrd = 2'd1;
      end
      OP_SIO: begin
        if (m_q == SIO_PRINT) begin
          if (!s_ok(sp_x) || !s_ok(sp_x - 1)) pl_flt = FLT_RANGE;
          pl_nrd = 2'd1;
        end else if (m_q == SIO_READ) begin
          if (!s_ok(sp_x + 1)) pl_flt = FLT_RANGE;
        end
      end
      default: pl_flt = FLT_OPC;
    endcase
  end

  // Execute step: new registers and the write plan.
  logic [FAULT_W-1:0] ex_flt;
  logic [CW-1:0]      ex_np;
  logic [SW-1:0]      ex_nb, ex_ns, ex_wa;
  logic [2:0]         ex_nw;
  logic [DATA_W-1:0]  ex_wv, ex_prod;
  logic               ex_pv, ex_halt, ex_div;
  always_comb begin
    ex_flt  = FLT_NONE;
    ex_np   = pc1;
    ex_nb   = bp_q;
    ex_ns   = sp_q;
    ex_wa   = sp_q;
    ex_nw   = 3'd0;
    ex_wv   = x_q;
    ex_pv   = 1'b0;
    ex_halt = 1'b0;
    ex_div  = 1'b0;
    ex_prod = DATA_W'(x_q * y_q);
    case (op_q)
      OP_LIT: begin
        ex_ns = SW'(sp_x + 1);
        ex_wa = ex_ns;
        ex_wv = m_q;
        ex_nw = 3'd1;
      end
      OP_OPR: begin
        if (m_q == OPR_RET) begin
          ex_nb = SW'(x_q);
          ex_np = CW'(y_q);
          ex_ns = SW'(bp_x - 1);
          if (!s_ok(sx(x_q)) || !c_ok(sx(y_q))) ex_flt = FLT_RANGE;
        end else if (m_q == OPR_NEG || m_q == OPR_ODD) begin
          ex_nw = 3'd1;
          ex_wv = (m_q == OPR_NEG) ? DATA_W'(-x_q) : {{(DATA_W-1){1'b0}}, x_q[0]};
        end else begin
          ex_ns = SW'(sp_x - 1);
          ex_wa = ex_ns;
          ex_nw = 3'd1;
          case (m_q)
            OPR_ADD: ex_wv = DATA_W'(x_q + y_q);
            OPR_SUB: ex_wv = DATA_W'(x_q - y_q);
            OPR_MUL: ex_wv = ex_prod;
            OPR_DIV, OPR_MOD: begin
              if (y_q == 0) ex_flt = FLT_DIV0;
              else ex_div = 1'b1;
            end
            OPR_EQL: ex_wv = DATA_W'(x_q == y_q);
            OPR_NEQ: ex_wv = DATA_W'(x_q != y_q);
            OPR_LSS: ex_wv = DATA_W'(x_q < y_q);
            OPR_LEQ: ex_wv = DATA_W'(x_q <= y_q);
            OPR_GTR: ex_wv = DATA_W'(x_q > y_q);
            default: ex_wv = DATA_W'(x_q >= y_q);
          endcase
        end
      end
      OP_LOD: begin
        ex_ns = SW'(sp_x + 1);
        ex_wa = ex_ns;
        ex_nw = 3'd1;
      end
      OP_STO: begin
        ex_ns = SW'(sp_x - 1);
        ex_wa = a_q;
        ex_nw = 3'd1;
      end
      OP_CAL: begin
        ex_wa = SW'(sp_x + 1);
        ex_nb = ex_wa;
        ex_np = CW'(m_q);
        ex_nw = 3'd4;
      end
      OP_INC: ex_ns = SW'(sp_x + m_x);
      OP_JMP: ex_np = CW'(m_q);
      OP_JPC: begin
        ex_ns = SW'(sp_x - 1);
        if (x_q == 0) begin
          if (!c_ok(m_x)) ex_flt = FLT_RANGE;
          ex_np = CW'(m_q);
        end
      end
      OP_SIO: begin
        if (m_q == SIO_PRINT) begin
          ex_ns = SW'(sp_x - 1);
          ex_pv = 1'b1;
        end else if (m_q == SIO_READ) begin
          ex_ns = SW'(sp_x + 1);
          ex_wa = ex_ns;
          ex_wv = rv_q;
          ex_nw = 3'd1;
        end else if (m_q == SIO_HALT) begin
          ex_np   = '0;
          ex_nb   = '0;
          ex_ns   = '0;
          ex_halt = 1'b1;
        end
      end
      default: ex_flt = FLT_OPC;
    endcase
  end

  // One restoring divide step on magnitudes.
  logic [DATA_W:0]   rem_sh, rem_sub;
  logic [DATA_W-1:0] quo_mag, rmd_mag;
  always_comb begin
    rem_sh  = {rem_q[DATA_W-1:0], dvd_q[DATA_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    quo_mag = dvd_q;
    rmd_mag = rem_q[DATA_W-1:0];
  end

  // Stack RAM ports.
  logic [DATA_W-1:0] cal_wv;
  always_comb begin
    case (wcnt_q)
      2'd0:    cal_wv = '0;
      2'd1:    cal_wv = b_q;
      2'd2:    cal_wv = DATA_W'(bp_q);
      default: cal_wv = DATA_W'(pc1);
    endcase
    mem_we    = 1'b0;
    mem_waddr = SW'(wa_q + SW'(wcnt_q));
    mem_wdata = cal_q ? cal_wv : wv_q;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_WR) begin
      mem_we = ({1'b0, wcnt_q} < nw_q);
    end
    case (state_q)
      S_WALK:  mem_raddr = SW'(b_x + 1);
      S_PLAN:  mem_raddr = SW'(pl_rd0);
      default: mem_raddr = rd1_q;
    endcase
  end

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pc_q        <= '0;
      bp_q        <= SW'(1);
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      walk_q      <= '0;
      nrd_q       <= '0;
      wcnt_q      <= '0;
      dcnt_q      <= '0;
    end else begin
      // Drop the result once taken, unless a new one is committed this cycle.
      if (out_valid_q && out_o.ready && state_q != S_FIN) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= SW'(clr_q + 1'b1);
          if (clr_q == SW'(STACK_DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_i.valid) begin
            op_q   <= in_i.opcode;
            m_q    <= in_i.operand;
            rv_q   <= in_i.read_value;
            b_q    <= DATA_W'(bp_q);
            flt_q  <= FLT_NONE;
            wcnt_q <= '0;
            if (in_i.opcode == OP_LOD || in_i.opcode == OP_STO || in_i.opcode == OP_CAL) begin
              walk_q <= (4'(in_i.level) > 4'(MAX_LEVELS)) ? 2'(MAX_LEVELS) : in_i.level;
            end else begin
              walk_q <= '0;
            end
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_q == 2'd0) begin
            state_q <= S_PLAN;
          end else if (!s_ok(b_x + 1)) begin
            flt_q   <= FLT_RANGE;
            state_q <= S_FIN;
          end else begin
            state_q <= S_WALKW;
          end
        end
        S_WALKW: begin
          b_q     <= mem_rdata;
          walk_q  <= walk_q - 2'd1;
          state_q <= S_WALK;
        end
        S_PLAN: begin
          a_q   <= SW'(a_x);
          rd1_q <= SW'(pl_rd1);
          nrd_q <= pl_nrd;
          if (pl_flt != FLT_NONE) begin
            flt_q   <= pl_flt;
            state_q <= S_FIN;
          end else if (pl_nrd == 2'd0) begin
            state_q <= S_EXEC;
          end else begin
            state_q <= S_RDA;
          end
        end
        S_RDA: begin
          x_q     <= mem_rdata;
          state_q <= (nrd_q == 2'd2) ? S_RDB : S_EXEC;
        end
        S_RDB: begin
          y_q     <= mem_rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          flt_q  <= ex_flt;
          np_q   <= ex_np;
          nb_q   <= ex_nb;
          ns_q   <= ex_ns;
          wa_q   <= ex_wa;
          nw_q   <= (ex_flt == FLT_NONE) ? ex_nw : 3'd0;
          wv_q   <= ex_wv;
          pvld_q <= ex_pv;
          halt_q <= ex_halt;
          cal_q  <= (op_q == OP_CAL);
          if (ex_div) begin
            dvd_q   <= x_q[DATA_W-1] ? DATA_W'(-x_q) : x_q;
            dvs_q   <= y_q[DATA_W-1] ? DATA_W'(-y_q) : y_q;
            rem_q   <= '0;
            dcnt_q  <= 6'(DATA_W);
            qneg_q  <= x_q[DATA_W-1] ^ y_q[DATA_W-1];
            rneg_q  <= x_q[DATA_W-1];
            ismod_q <= (m_q == OPR_MOD);
            state_q <= S_DIV;
          end else begin
            state_q <= (ex_flt == FLT_NONE) ? S_WR : S_FIN;
          end
        end
        S_DIV: begin
          if (dcnt_q == 6'd0) begin
            if (ismod_q) wv_q <= rneg_q ? DATA_W'(-rmd_mag) : rmd_mag;
            else         wv_q <= qneg_q ? DATA_W'(-quo_mag) : quo_mag;
            state_q <= S_WR;
          end else begin
            if (!rem_sub[DATA_W]) begin
              rem_q <= rem_sub;
              dvd_q <= {dvd_q[DATA_W-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
            end
            dcnt_q <= dcnt_q - 6'd1;
          end
        end
        S_WR: begin
          // Advance through the planned writes, one word a cycle.
          if ({1'b0, wcnt_q} + 3'd1 >= nw_q) state_q <= S_FIN;
          else wcnt_q <= wcnt_q + 2'd1;
        end
        S_FIN: begin
          // Hold until the result register is free, then commit.
          if (out_free) begin
            out_valid_q <= 1'b1;
            o_flt_q     <= flt_q;
            o_bp_q      <= bp_q;
            o_sp_q      <= sp_q;
            o_pc_q      <= pc_q;
            o_pv_q      <= 1'b0;
            o_pval_q    <= '0;
            o_halt_q    <= 1'b0;
            if (flt_q == FLT_NONE) begin
              pc_q     <= np_q;
              bp_q     <= nb_q;
              sp_q     <= ns_q;
              o_pc_q   <= np_q;
              o_bp_q   <= nb_q;
              o_sp_q   <= ns_q;
              o_pv_q   <= pvld_q;
              o_pval_q <= pvld_q ? x_q : '0;
              o_halt_q <= halt_q;
            end else if (flt_q == FLT_OPC || flt_q == FLT_FUNC) begin
              pc_q   <= pc1;
              o_pc_q <= pc1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.next_pc     = o_pc_q;
  assign out_o.base_ptr    = o_bp_q;
  assign out_o.stack_ptr   = o_sp_q;
  assign out_o.print_valid = o_pv_q;
  assign out_o.print_value = o_pval_q;
  assign out_o.halted      = o_halt_q;
  assign out_o.fault       = o_flt_q;
endmodule
`default_nettype wire

### hdl/pm0_checker.sv
// Port-level checks on the PM/0 execute unit, bound to its top level.
`default_nettype none
module pm0_checker import pm0_pkg::*; #(
  parameter int CW = 9,
  parameter int SW = 11
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [CW-1:0]       next_pc,
  input wire logic [SW-1:0]       base_ptr,
  input wire logic [SW-1:0]       stack_ptr,
  input wire logic                print_valid,
  input wire logic                halted,
  input wire logic [FAULT_W-1:0]  fault
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(fault) && $stable(next_pc))
    else $error("result changed while stalled");

  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && fault != FLT_NONE |-> !print_valid && !halted)
    else $error("faulting item printed or halted");

  a_halt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && halted |-> next_pc == '0 && base_ptr == '0 && stack_ptr == '0)
    else $error("halt left registers non-zero");

  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(print_valid && halted))
    else $error("print and halt on one item");
endmodule

bind pl0_stack_machine_execute pm0_checker #(.CW(CW), .SW(SW)) u_pm0_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .next_pc     (out_o.next_pc),
  .base_ptr    (out_o.base_ptr),
  .stack_ptr   (out_o.stack_ptr),
  .print_valid (out_o.print_valid),
  .halted      (out_o.halted),
  .fault       (out_o.fault)
);
`default_nettype wire

### tb/sv/pm0_execute_checker.sv
// Checker: watches the instruction and result channels, predicts each result and compares.
module pm0_execute_checker import pm0_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pm0_in_if    in_mon,
  pm0_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_N = STACK_DEPTH_DEF;
  localparam int CODE_N  = CODE_DEPTH_DEF;
  localparam int LEVEL_N = MAX_LEVELS_DEF;

  typedef struct packed {
    logic [8:0]         next_pc;
    logic [10:0]        base_ptr;
    logic [10:0]        stack_ptr;
    logic               print_valid;
    logic [31:0]        print_value;
    logic               halted;
    logic [FAULT_W-1:0] fault;
  } machine_result_t;

  logic [8:0]      pc_q;
  logic [10:0]     bp_q;
  logic [10:0]     sp_q;
  logic [31:0]     stack_mem [STACK_N];
  machine_result_t results_q [$];

  function automatic bit in_stack(longint a);
    return a >= 0 && a < STACK_N;
  endfunction

  function automatic bit in_code(longint a);
    return a >= 0 && a < CODE_N;
  endfunction

  function automatic longint word_at(longint a);
    return longint'($signed(stack_mem[a]));
  endfunction

  // Follow static links; fail on a link read outside the stack.
  function automatic bit follow_links(logic [1:0] lv, longint base, output longint res);
    longint b;
    int n;
    b = base;
    n = (lv > LEVEL_N) ? LEVEL_N : lv;
    res = 0;
    for (int i = 0; i < n; i++) begin
      if (!in_stack(b + 1)) return 0;
      b = word_at(b + 1);
    end
    res = b;
    return 1;
  endfunction

  function automatic void execute_instr(logic [3:0] op, logic [1:0] lv,
                                        logic signed [31:0] m32, logic [31:0] rv);
    longint m, sp, bp, pc1, np, nb, ns, b, x, y, a;
    longint wa [4];
    logic [31:0] wv [4];
    int nw;
    logic [FAULT_W-1:0] flt;
    logic pv, hl;
    logic [31:0] pval;
    machine_result_t r;
    m = m32;
    sp = sp_q;
    bp = bp_q;
    pc1 = longint'(pc_q) + 1;
    if (pc1 >= CODE_N) pc1 = 0;
    np = pc1; nb = bp; ns = sp; nw = 0; b = 0; a = 0;
    flt = FLT_NONE; pv = 0; hl = 0; pval = '0;
    case (op)
      OP_LIT: begin
        ns = sp + 1;
        if (!in_stack(ns)) flt = FLT_RANGE;
        else begin wa[0] = ns; wv[0] = m32; nw = 1; end
      end
      OP_OPR: begin
        if (m == OPR_RET) begin
          if (!in_stack(bp - 1) || !in_stack(bp + 3)) flt = FLT_RANGE;
          else begin
            nb = word_at(bp + 2);
            np = word_at(bp + 3);
            ns = bp - 1;
            if (!in_stack(nb) || !in_code(np)) flt = FLT_RANGE;
          end
        end else if (m == OPR_NEG || m == OPR_ODD) begin
          if (!in_stack(sp)) flt = FLT_RANGE;
          else begin
            x = word_at(sp);
            wa[0] = sp;
            wv[0] = (m == OPR_NEG) ? 32'(-x) : {31'd0, x[0]};
            nw = 1;
          end
        end else if (m >= OPR_ADD && m <= OPR_GEQ) begin
          ns = sp - 1;
          if (!in_stack(ns) || !in_stack(sp)) flt = FLT_RANGE;
          else begin
            x = word_at(ns);
            y = word_at(sp);
            case (m)
              OPR_ADD: a = x + y;
              OPR_SUB: a = x - y;
              OPR_MUL: a = x * y;
              OPR_DIV: if (y == 0) flt = FLT_DIV0; else a = x / y;
              OPR_MOD: if (y == 0) flt = FLT_DIV0; else a = x % y;
              OPR_EQL: a = x == y;
              OPR_NEQ: a = x != y;
              OPR_LSS: a = x < y;
              OPR_LEQ: a = x <= y;
              OPR_GTR: a = x > y;
              default: a = x >= y;
            endcase
            if (flt == FLT_NONE) begin wa[0] = ns; wv[0] = 32'(a); nw = 1; end
          end
        end else begin
          flt = FLT_FUNC;
        end
      end
      OP_LOD: begin
        if (!follow_links(lv, bp, b)) flt = FLT_RANGE;
        else begin
          a = b + m;
          ns = sp + 1;
          if (!in_stack(a) || !in_stack(ns)) flt = FLT_RANGE;
          else begin wa[0] = ns; wv[0] = stack_mem[a]; nw = 1; end
        end
      end
      OP_STO: begin
        if (!follow_links(lv, bp, b)) flt = FLT_RANGE;
        else begin
          a = b + m;
          ns = sp - 1;
          if (!in_stack(a) || !in_stack(sp) || !in_stack(ns)) flt = FLT_RANGE;
          else begin wa[0] = a; wv[0] = stack_mem[sp]; nw = 1; end
        end
      end
      OP_CAL: begin
        if (!follow_links(lv, bp, b)) flt = FLT_RANGE;
        else if (!in_stack(sp + 1) || !in_stack(sp + 4) || !in_code(m)) flt = FLT_RANGE;
        else begin
          wa[0] = sp + 1; wv[0] = '0;
          wa[1] = sp + 2; wv[1] = 32'(b);
          wa[2] = sp + 3; wv[2] = 32'(bp);
          wa[3] = sp + 4; wv[3] = 32'(pc1);
          nw = 4;
          nb = sp + 1;
          np = m;
        end
      end
      OP_INC: begin
        ns = sp + m;
        if (!in_stack(ns)) flt = FLT_RANGE;
      end
      OP_JMP: begin
        if (!in_code(m)) flt = FLT_RANGE;
        else np = m;
      end
      OP_JPC: begin
        ns = sp - 1;
        if (!in_stack(sp) || !in_stack(ns)) flt = FLT_RANGE;
        else if (stack_mem[sp] == '0) begin
          if (!in_code(m)) flt = FLT_RANGE;
          else np = m;
        end
      end
      OP_SIO: begin
        if (m == SIO_PRINT) begin
          ns = sp - 1;
          if (!in_stack(sp) || !in_stack(ns)) flt = FLT_RANGE;
          else begin pv = 1; pval = stack_mem[sp]; end
        end else if (m == SIO_READ) begin
          ns = sp + 1;
          if (!in_stack(ns)) flt = FLT_RANGE;
          else begin wa[0] = ns; wv[0] = rv; nw = 1; end
        end else if (m == SIO_HALT) begin
          np = 0; nb = 0; ns = 0; hl = 1;
        end
      end
      default: flt = FLT_OPC;
    endcase

    if (flt == FLT_NONE) begin
      for (int k = 0; k < nw; k++) stack_mem[wa[k]] = wv[k];
      pc_q = 9'(np);
      bp_q = 11'(nb);
      sp_q = 11'(ns);
    end else begin
      if (flt == FLT_OPC || flt == FLT_FUNC) pc_q = 9'(pc1);
      pv = 0; pval = '0; hl = 0;
    end
    r.next_pc = pc_q;
    r.base_ptr = bp_q;
    r.stack_ptr = sp_q;
    r.print_valid = pv;
    r.print_value = pval;
    r.halted = hl;
    r.fault = flt;
    results_q.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_result();
    machine_result_t e;
    if (results_q.size() == 0) begin
      $display("%0t: result item with no instruction outstanding", $realtime);
      fail_count_o++;
      return;
    end
    e = results_q.pop_front();
    if (out_mon.next_pc !== e.next_pc) report_mismatch("next_pc", out_mon.next_pc, e.next_pc);
    if (out_mon.base_ptr !== e.base_ptr)
      report_mismatch("base_ptr", out_mon.base_ptr, e.base_ptr);
    if (out_mon.stack_ptr !== e.stack_ptr)
      report_mismatch("stack_ptr", out_mon.stack_ptr, e.stack_ptr);
    if (out_mon.print_valid !== e.print_valid)
      report_mismatch("print_valid", out_mon.print_valid, e.print_valid);
    if (out_mon.print_value !== e.print_value)
      report_mismatch("print_value", out_mon.print_value, e.print_value);
    if (out_mon.halted !== e.halted) report_mismatch("halted", out_mon.halted, e.halted);
    if (out_mon.fault !== e.fault) report_mismatch("fault", out_mon.fault, e.fault);
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q = '0;
      bp_q = 11'd1;
      sp_q = '0;
      for (int i = 0; i < STACK_N; i++) stack_mem[i] = '0;
      results_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        execute_instr(in_mon.opcode, in_mon.level, in_mon.operand, in_mon.read_value);
      if (out_mon.valid && out_mon.ready) compare_result();
    end
    pending_o <= results_q.size();
  end

endmodule

### tb/sv/tb_pl0_stack_machine_execute.sv
// Testbench top: clock, reset, instruction stimulus, result back-pressure and verdict.
module tb_pl0_stack_machine_execute import pm0_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_500_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;
  int   cycles = 0;

  pm0_in_if  in_if ();
  pm0_out_if out_if ();

  pl0_stack_machine_execute i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pm0_execute_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.level = '0;
    in_if.operand = '0;
    in_if.read_value = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_instr(logic [3:0] op, logic [1:0] lv, logic [31:0] m, logic [31:0] rv);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.level <= lv;
    in_if.operand <= m;
    in_if.read_value <= rv;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_random_instr();
    logic [3:0] op;
    logic [1:0] lv;
    logic [31:0] m;
    int r;
    r = $urandom_range(99);
    lv = ($urandom_range(9) < 7) ? 2'd0 : 2'($urandom);
    m = $urandom;
    if (r < 4) begin
      op = ($urandom_range(6) == 0) ? 4'd0 : 4'($urandom_range(10, 15));
    end else if (r < 22) begin
      op = OP_LIT;
      if ($urandom_range(1) == 0) m = 32'($urandom_range(0, 16)) - 32'd8;
    end else if (r < 42) begin
      op = OP_OPR;
      if ($urandom_range(19) != 0) m = 32'($urandom_range(0, 13));
      else if ($urandom_range(1) == 0) m = 32'($urandom_range(14, 15));
    end else if (r < 52) begin
      op = OP_LOD;
      if ($urandom_range(9) != 0) m = 32'($urandom_range(0, 8));
    end else if (r < 61) begin
      op = OP_STO;
      if ($urandom_range(9) != 0) m = 32'($urandom_range(0, 8));
    end else if (r < 66) begin
      op = OP_CAL;
      if ($urandom_range(9) != 0) m = 32'($urandom_range(0, 511));
    end else if (r < 73) begin
      op = OP_INC;
      if ($urandom_range(9) != 0) m = 32'($urandom_range(0, 10)) - 32'd4;
    end else if (r < 78) begin
      op = OP_JMP;
      if ($urandom_range(9) != 0) m = 32'($urandom_range(0, 520));
    end else if (r < 85) begin
      op = OP_JPC;
      if ($urandom_range(9) != 0) m = 32'($urandom_range(0, 520));
    end else begin
      op = OP_SIO;
      if ($urandom_range(9) != 0) m = 32'($urandom_range(1, 3));
      else if ($urandom_range(1) == 0) m = 32'($urandom_range(0, 4));
    end
    send_instr(op, lv, m, $urandom);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, wrap-around arithmetic and the division corner cases
    send_instr(OP_LIT, 2'd0, 32'h7fff_ffff, '0);
    send_instr(OP_LIT, 2'd0, 32'h8000_0000, '0);
    send_instr(OP_OPR, 2'd0, OPR_ADD, '0);
    send_instr(OP_LIT, 2'd0, 32'h8000_0000, '0);
    send_instr(OP_LIT, 2'd0, 32'hffff_ffff, '0);
    send_instr(OP_OPR, 2'd0, OPR_DIV, '0);
    send_instr(OP_LIT, 2'd0, 32'h8000_0000, '0);
    send_instr(OP_LIT, 2'd0, 32'hffff_ffff, '0);
    send_instr(OP_OPR, 2'd0, OPR_MOD, '0);
    send_instr(OP_LIT, 2'd0, 32'd0, '0);
    send_instr(OP_OPR, 2'd0, OPR_DIV, '0);
    send_instr(OP_OPR, 2'd0, OPR_MOD, '0);
    send_instr(OP_LIT, 2'd0, 32'hffff_fff9, '0);
    send_instr(OP_OPR, 2'd0, OPR_ODD, '0);
    send_instr(OP_SIO, 2'd0, SIO_READ, 32'hffff_ffff);
    send_instr(OP_SIO, 2'd0, SIO_PRINT, '0);
    send_instr(OP_CAL, 2'd3, 32'd511, '0);
    send_instr(OP_LOD, 2'd3, 32'd2, '0);
    send_instr(OP_STO, 2'd2, 32'hffff_ffff, '0);
    send_instr(OP_OPR, 2'd0, OPR_RET, '0);
    send_instr(OP_JPC, 2'd0, 32'd600, '0);
    send_instr(OP_JMP, 2'd0, 32'd512, '0);
    send_instr(4'd0, 2'd0, '0, '0);
    send_instr(4'd15, 2'd3, 32'hffff_ffff, 32'hffff_ffff);
    send_instr(OP_OPR, 2'd0, 32'd14, '0);
    send_instr(OP_SIO, 2'd0, 32'd0, '0);
    send_instr(OP_INC, 2'd0, 32'h8000_0000, '0);
    send_instr(OP_SIO, 2'd0, SIO_HALT, '0);

    // No idling, sender gaps, receiver stalls, then both
    for (int phase = 0; phase < 4; phase++) begin
      send_gap_pct   = (phase == 1) ? 60 : (phase == 3) ? 17 : 0;
      recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 17 : 0;
      for (int i = 0; i < 335; i++) send_random_instr();
    end
    in_if.valid <= 1'b0;
    recv_stall_pct = 0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/pm0_pkg.sv
hdl/pm0_if.sv
hdl/pm0_ram.sv
hdl/pl0_stack_machine_execute.sv
hdl/pm0_checker.sv
tb/sv/pm0_execute_checker.sv
tb/sv/tb_pl0_stack_machine_execute.sv
